[rtl/rwst_pkg.sv]
// Shared constants, codes and types of the random-walk maze unit.
`timescale 1ns / 1ps

package rwst_pkg;

  // Default grid capacity, handed to the top level as parameter defaults.
  localparam int unsigned MAX_COLS_DEF = 32;
  localparam int unsigned MAX_ROWS_DEF = 32;

  // Fixed widths of the configuration port and of the result fields.
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned POS_OUT_W  = 5;
  localparam int unsigned CNT_OUT_W  = 11;

  // Reset values of the configuration registers.
  localparam int unsigned GRID_COLS_RST = 20;
  localparam int unsigned GRID_ROWS_RST = 24;
  localparam int unsigned START_COL_RST = 0;
  localparam int unsigned START_ROW_RST = 0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd3;

  // Request operations.
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_STEP    = 1'b1;

  // Step directions.
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Side of the removed wall.
  localparam logic WALL_LEFT = 1'b0;
  localparam logic WALL_TOP  = 1'b1;

  // Control of the visited map.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } map_ctl_t;

endpackage

[rtl/rwst_map.sv]
// Visited map: one row word per grid row, with a valid bit per row.
`timescale 1ns / 1ps

module rwst_map import rwst_pkg::*; #(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  localparam int unsigned YW = $clog2(MAX_ROWS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  map_ctl_t            ctl_i,
  input  logic [YW-1:0]       rd_row_i,
  input  logic [YW-1:0]       wr_row_i,
  input  logic [MAX_COLS-1:0] wr_data_i,
  output logic [MAX_COLS-1:0] rd_data_o
);

  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data_q;
  logic                rd_vld_q;
  logic [MAX_ROWS-1:0] row_vld_q;
  logic [MAX_ROWS-1:0] row_vld_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  // A row whose valid bit is clear has not been written since the last
  // restart and reads as all unvisited.
  always_comb begin
    row_vld_d = ctl_i.clr_all ? '0 : row_vld_q;
    if (ctl_i.wr_en) begin
      row_vld_d[wr_row_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      row_vld_q <= row_vld_d;
      if (ctl_i.rd_en) begin
        rd_vld_q <= row_vld_q[rd_row_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.rd_en && ctl_i.wr_en))
    else $error("map read and write in the same cycle");

  a_clear_marks_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr_all |-> ctl_i.wr_en)
    else $error("map cleared without marking the start cell");

endmodule

[rtl/rwst_move.sv]
// Neighbour cell of the walker for one direction, and whether it is on the grid.
`timescale 1ns / 1ps

module rwst_move import rwst_pkg::*; #(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
  localparam int unsigned XW  = $clog2(MAX_COLS),
  localparam int unsigned YW  = $clog2(MAX_ROWS),
  localparam int unsigned UCW = $clog2(MAX_COLS + 1),
  localparam int unsigned URW = $clog2(MAX_ROWS + 1)
) (
  input  logic [XW-1:0]  walker_x_i,
  input  logic [YW-1:0]  walker_y_i,
  input  logic [UCW-1:0] used_cols_i,
  input  logic [URW-1:0] used_rows_i,
  input  logic [1:0]     direction_i,
  output logic [XW-1:0]  next_x_o,
  output logic [YW-1:0]  next_y_o,
  output logic           inside_o
);

  logic [UCW-1:0] x_plus;
  logic [URW-1:0] y_plus;

  assign x_plus = UCW'(walker_x_i) + UCW'(1);
  assign y_plus = URW'(walker_y_i) + URW'(1);

  always_comb begin
    next_x_o = walker_x_i;
    next_y_o = walker_y_i;
    inside_o = 1'b1;
    case (direction_i)
      DIR_LEFT: begin
        if (walker_x_i == '0) inside_o = 1'b0;
        else next_x_o = walker_x_i - XW'(1);
      end
      DIR_RIGHT: begin
        if (x_plus >= used_cols_i) inside_o = 1'b0;
        else next_x_o = walker_x_i + XW'(1);
      end
      DIR_UP: begin
        if (walker_y_i == '0) inside_o = 1'b0;
        else next_y_o = walker_y_i - YW'(1);
      end
      default: begin
        if (y_plus >= used_rows_i) inside_o = 1'b0;
        else next_y_o = walker_y_i + YW'(1);
      end
    endcase
  end

endmodule

[rtl/random_walk_spanning_tree_maze_unit.sv]
// Top level of the random-walk spanning-tree maze unit.
`timescale 1ns / 1ps

// The unit walks a cell pointer over a grid of up to MAX_COLS by MAX_ROWS
// cells and builds a spanning-tree maze from it. A restart request latches
// the grid size (clamped to one cell at least and to the capacity), clears
// the visited map, puts the walker on the start cell (clamped into the grid)
// and marks it visited. A step request moves the walker one cell; a move into
// a cell not yet visited reports the removed wall, always the left or top wall
// of the cell further along. Every request gives exactly one result. Each
// request runs through two states: in idle the neighbour cell is worked out
// and its row of the visited map is read, in exec the read row is checked,
// written back and the result is registered. Since the map read is registered
// and each step's address depends on the walker position left by the
// previous step, a new request is taken only once the last one has left exec.
// A new request is taken while an earlier result still waits in the output
// register; a result held by the downstream side holds the unit in exec. Each
// map row carries a valid bit that reset and restart clear at once, so no
// clearing pass is ever run. Configuration writes are always taken and apply
// to the next restart.

module random_walk_spanning_tree_maze_unit import rwst_pkg::*; #(
  parameter int unsigned MAX_COLS = MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [1:0]            direction_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  accepted_o,
  output logic                  carved_o,
  output logic [POS_OUT_W-1:0]  wall_col_o,
  output logic [POS_OUT_W-1:0]  wall_row_o,
  output logic                  wall_side_o,
  output logic [POS_OUT_W-1:0]  walker_col_o,
  output logic [POS_OUT_W-1:0]  walker_row_o,
  output logic [CNT_OUT_W-1:0]  cells_left_o,
  output logic                  done_res_o
);

  localparam int unsigned XW   = $clog2(MAX_COLS);
  localparam int unsigned YW   = $clog2(MAX_ROWS);
  localparam int unsigned UCW  = $clog2(MAX_COLS + 1);
  localparam int unsigned URW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CNTW = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int unsigned UC_RST = (GRID_COLS_RST > MAX_COLS) ? MAX_COLS : GRID_COLS_RST;
  localparam int unsigned UR_RST = (GRID_ROWS_RST > MAX_ROWS) ? MAX_ROWS : GRID_ROWS_RST;

  // Sequencer states: idle waits for a request, exec finishes it.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] grid_cols_q, grid_rows_q;
  logic [POS_OUT_W-1:0]  start_col_q, start_row_q;

  // Walk state.
  logic [UCW-1:0]  used_cols_q, used_cols_d;
  logic [URW-1:0]  used_rows_q, used_rows_d;
  logic [XW-1:0]   walker_x_q, walker_x_d;
  logic [YW-1:0]   walker_y_q, walker_y_d;
  logic [CNTW-1:0] count_q, count_d;

  // Request held between the idle and exec states.
  logic            state_q;
  logic            op_q;
  logic [1:0]      dir_q;
  logic [XW-1:0]   next_x_q;
  logic [YW-1:0]   next_y_q;
  logic            inside_q;

  // Output register.
  logic                 out_valid_q;
  logic                 accepted_q, accepted_d;
  logic                 carved_q, carved_d;
  logic [POS_OUT_W-1:0] wall_col_q, wall_col_d;
  logic [POS_OUT_W-1:0] wall_row_q, wall_row_d;
  logic                 wall_side_q, wall_side_d;
  logic [POS_OUT_W-1:0] walker_col_q;
  logic [POS_OUT_W-1:0] walker_row_q;
  logic [CNT_OUT_W-1:0] cells_left_q;
  logic                 done_res_q;

  logic          in_fire, commit;
  logic [XW-1:0] next_x;
  logic [YW-1:0] next_y;
  logic          on_grid;

  map_ctl_t            map_ctl;
  logic [YW-1:0]       map_wr_row;
  logic [MAX_COLS-1:0] map_wr_data;
  logic [MAX_COLS-1:0] map_rd_data;

  logic [UCW-1:0]  new_cols;
  logic [URW-1:0]  new_rows;
  logic [XW-1:0]   new_x;
  logic [YW-1:0]   new_y;
  logic [CNTW-1:0] new_count;
  logic            step_live;
  logic            cell_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  // The result is written once the output register is empty or being emptied.
  assign commit      = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  // Neighbour of the current walker for the incoming request.
  rwst_move #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_move (
    .walker_x_i  (walker_x_q),
    .walker_y_i  (walker_y_q),
    .used_cols_i (used_cols_q),
    .used_rows_i (used_rows_q),
    .direction_i (direction_i),
    .next_x_o    (next_x),
    .next_y_o    (next_y),
    .inside_o    (on_grid)
  );

  rwst_map #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (map_ctl),
    .rd_row_i  (next_y),
    .wr_row_i  (map_wr_row),
    .wr_data_i (map_wr_data),
    .rd_data_o (map_rd_data)
  );

  // Grid size and start cell as latched by a restart, clamped into range.
  always_comb begin
    if (grid_cols_q == '0) new_cols = UCW'(1);
    else if (int'(grid_cols_q) > int'(MAX_COLS)) new_cols = UCW'(MAX_COLS);
    else new_cols = UCW'(grid_cols_q);
    if (grid_rows_q == '0) new_rows = URW'(1);
    else if (int'(grid_rows_q) > int'(MAX_ROWS)) new_rows = URW'(MAX_ROWS);
    else new_rows = URW'(grid_rows_q);
    new_x = (int'(start_col_q) < int'(new_cols)) ? XW'(start_col_q) : XW'(new_cols - UCW'(1));
    new_y = (int'(start_row_q) < int'(new_rows)) ? YW'(start_row_q) : YW'(new_rows - URW'(1));
    new_count = CNTW'(CNTW'(new_cols) * CNTW'(new_rows) - CNTW'(1));
  end

  assign step_live = (op_q == OP_STEP) && (count_q != '0) && inside_q;
  assign cell_free = !map_rd_data[next_x_q];

  always_comb begin
    map_ctl         = '0;
    map_ctl.rd_en   = in_fire && (op_i == OP_STEP);
    map_wr_row      = next_y_q;
    map_wr_data     = map_rd_data | (MAX_COLS'(1) << next_x_q);
    used_cols_d     = used_cols_q;
    used_rows_d     = used_rows_q;
    walker_x_d      = walker_x_q;
    walker_y_d      = walker_y_q;
    count_d         = count_q;
    accepted_d      = 1'b0;
    carved_d        = 1'b0;
    wall_col_d      = '0;
    wall_row_d      = '0;
    wall_side_d     = WALL_LEFT;
    if (commit) begin
      if (op_q == OP_RESTART) begin
        // Clear every row and mark the start cell in the same cycle.
        map_ctl.clr_all = 1'b1;
        map_ctl.wr_en   = 1'b1;
        map_wr_row      = new_y;
        map_wr_data     = MAX_COLS'(1) << new_x;
        used_cols_d     = new_cols;
        used_rows_d     = new_rows;
        walker_x_d      = new_x;
        walker_y_d      = new_y;
        count_d         = new_count;
      end else if (step_live) begin
        accepted_d = 1'b1;
        walker_x_d = next_x_q;
        walker_y_d = next_y_q;
        if (cell_free) begin
          map_ctl.wr_en = 1'b1;
          count_d       = count_q - CNTW'(1);
          carved_d      = 1'b1;
          // The shared wall belongs to whichever cell lies further along.
          if (dir_q inside {DIR_LEFT, DIR_UP}) begin
            wall_col_d = POS_OUT_W'(walker_x_q);
            wall_row_d = POS_OUT_W'(walker_y_q);
          end else begin
            wall_col_d = POS_OUT_W'(next_x_q);
            wall_row_d = POS_OUT_W'(next_y_q);
          end
          wall_side_d = (dir_q inside {DIR_UP, DIR_DOWN}) ? WALL_TOP : WALL_LEFT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= CFG_DATA_W'(GRID_COLS_RST);
      grid_rows_q <= CFG_DATA_W'(GRID_ROWS_RST);
      start_col_q <= POS_OUT_W'(START_COL_RST);
      start_row_q <= POS_OUT_W'(START_ROW_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i;
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        CFG_START_COL: start_col_q <= POS_OUT_W'(cfg_data_i);
        CFG_START_ROW: start_row_q <= POS_OUT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      used_cols_q <= UCW'(UC_RST);
      used_rows_q <= URW'(UR_RST);
      walker_x_q  <= '0;
      walker_y_q  <= '0;
      count_q     <= '0;
    end else begin
      used_cols_q <= used_cols_d;
      used_rows_q <= used_rows_d;
      walker_x_q  <= walker_x_d;
      walker_y_q  <= walker_y_d;
      count_q     <= count_d;
      if (in_fire) begin
        state_q <= ST_EXEC;
      end else if (commit) begin
        state_q <= ST_IDLE;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_i;
      dir_q    <= direction_i;
      next_x_q <= next_x;
      next_y_q <= next_y;
      inside_q <= on_grid;
    end
    if (commit) begin
      accepted_q   <= accepted_d;
      carved_q     <= carved_d;
      wall_col_q   <= wall_col_d;
      wall_row_q   <= wall_row_d;
      wall_side_q  <= wall_side_d;
      walker_col_q <= POS_OUT_W'(walker_x_d);
      walker_row_q <= POS_OUT_W'(walker_y_d);
      cells_left_q <= CNT_OUT_W'(count_d);
      done_res_q   <= (count_d == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign carved_o     = carved_q;
  assign wall_col_o   = wall_col_q;
  assign wall_row_o   = wall_row_q;
  assign wall_side_o  = wall_side_q;
  assign walker_col_o = walker_col_q;
  assign walker_row_o = walker_row_q;
  assign cells_left_o = cells_left_q;
  assign done_res_o   = done_res_q;

  a_carve_needs_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && carved_o) |-> accepted_o)
    else $error("wall carved on a rejected step");

  a_count_steps_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_q == OP_STEP) |=>
      (count_q == $past(count_q) || count_q == $past(count_q) - CNTW'(1)))
    else $error("unvisited count moved by more than one cell on a step");

  a_walker_on_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(walker_x_q) < int'(used_cols_q)) && (int'(walker_y_q) < int'(used_rows_q)))
    else $error("walker left the grid");

  a_no_read_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !map_ctl.rd_en)
    else $error("map read would overwrite the row under test");

endmodule

[verif/maze_walk_sb_pkg.sv]
// Scoreboard of the maze unit: a model of the walk and the queue of expected results.
`timescale 1ns / 1ps

package maze_walk_sb_pkg;
  import rwst_pkg::*;

  typedef struct packed {
    logic                 accepted;
    logic                 carved;
    logic [POS_OUT_W-1:0] wall_col;
    logic [POS_OUT_W-1:0] wall_row;
    logic                 wall_side;
    logic [POS_OUT_W-1:0] walker_col;
    logic [POS_OUT_W-1:0] walker_row;
    logic [CNT_OUT_W-1:0] cells_left;
    logic                 done;
  } walk_result_t;

  class maze_walk_scoreboard;
    int unsigned  cols_reg;
    int unsigned  rows_reg;
    int unsigned  start_col_reg;
    int unsigned  start_row_reg;
    int unsigned  grid_cols;
    int unsigned  grid_rows;
    int unsigned  walker_col;
    int unsigned  walker_row;
    int unsigned  cells_left;
    bit           visited [MAX_ROWS_DEF][MAX_COLS_DEF];
    walk_result_t walk_results_q[$];
    int unsigned  results_seen;
    int unsigned  mismatches;

    function new();
      cols_reg      = GRID_COLS_RST;
      rows_reg      = GRID_ROWS_RST;
      start_col_reg = START_COL_RST;
      start_row_reg = START_ROW_RST;
      grid_cols     = clamp_size(cols_reg, MAX_COLS_DEF);
      grid_rows     = clamp_size(rows_reg, MAX_ROWS_DEF);
      walker_col    = 0;
      walker_row    = 0;
      cells_left    = 0;
      results_seen  = 0;
      mismatches    = 0;
      foreach (visited[r, c]) visited[r][c] = 1'b0;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_COLS: cols_reg = 32'(data);
        CFG_GRID_ROWS: rows_reg = 32'(data);
        CFG_START_COL: start_col_reg = 32'(data[POS_OUT_W-1:0]);
        CFG_START_ROW: start_row_reg = 32'(data[POS_OUT_W-1:0]);
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(logic op, logic [1:0] dir);
      walk_result_t r;
      int unsigned  nx;
      int unsigned  ny;
      bit           on_grid;
      r = '0;
      if (op == OP_RESTART) begin
        grid_cols = clamp_size(cols_reg, MAX_COLS_DEF);
        grid_rows = clamp_size(rows_reg, MAX_ROWS_DEF);
        foreach (visited[rr, cc]) visited[rr][cc] = 1'b0;
        walker_col = (start_col_reg < grid_cols) ? start_col_reg : grid_cols - 1;
        walker_row = (start_row_reg < grid_rows) ? start_row_reg : grid_rows - 1;
        visited[walker_row][walker_col] = 1'b1;
        cells_left = grid_cols * grid_rows - 1;
      end else if (cells_left != 0) begin
        nx      = walker_col;
        ny      = walker_row;
        on_grid = 1'b1;
        case (dir)
          DIR_LEFT: begin
            if (walker_col == 0) on_grid = 1'b0; else nx = walker_col - 1;
          end
          DIR_RIGHT: begin
            if (walker_col + 1 >= grid_cols) on_grid = 1'b0; else nx = walker_col + 1;
          end
          DIR_UP: begin
            if (walker_row == 0) on_grid = 1'b0; else ny = walker_row - 1;
          end
          default: begin
            if (walker_row + 1 >= grid_rows) on_grid = 1'b0; else ny = walker_row + 1;
          end
        endcase
        if (on_grid) begin
          r.accepted = 1'b1;
          if (!visited[ny][nx]) begin
            visited[ny][nx] = 1'b1;
            cells_left--;
            r.carved = 1'b1;
            // The shared wall belongs to whichever cell lies further along the grid.
            if (dir == DIR_LEFT || dir == DIR_UP) begin
              r.wall_col = POS_OUT_W'(walker_col);
              r.wall_row = POS_OUT_W'(walker_row);
            end else begin
              r.wall_col = POS_OUT_W'(nx);
              r.wall_row = POS_OUT_W'(ny);
            end
            r.wall_side = (dir == DIR_UP || dir == DIR_DOWN) ? WALL_TOP : WALL_LEFT;
          end
          walker_col = nx;
          walker_row = ny;
        end
      end
      r.walker_col = POS_OUT_W'(walker_col);
      r.walker_row = POS_OUT_W'(walker_row);
      r.cells_left = CNT_OUT_W'(cells_left);
      r.done       = (cells_left == 0);
      walk_results_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("result %0d: %s is %0d, expected %0d", results_seen, name, got, want));
    endtask

    task check_result(walk_result_t got);
      walk_result_t want;
      results_seen++;
      if (walk_results_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", results_seen));
        return;
      end
      want = walk_results_q.pop_front();
      compare_field("accepted", 32'(got.accepted), 32'(want.accepted));
      compare_field("carved", 32'(got.carved), 32'(want.carved));
      compare_field("wall_col", 32'(got.wall_col), 32'(want.wall_col));
      compare_field("wall_row", 32'(got.wall_row), 32'(want.wall_row));
      compare_field("wall_side", 32'(got.wall_side), 32'(want.wall_side));
      compare_field("walker_col", 32'(got.walker_col), 32'(want.walker_col));
      compare_field("walker_row", 32'(got.walker_row), 32'(want.walker_row));
      compare_field("cells_left", 32'(got.cells_left), 32'(want.cells_left));
      compare_field("done_res", 32'(got.done), 32'(want.done));
    endtask
  endclass

endpackage

[verif/random_walk_spanning_tree_maze_unit_tb.sv]
// Self-checking testbench of the random-walk spanning-tree maze unit.
`timescale 1ns / 1ps

// Requests are driven on the falling edge and every handshake is sampled on
// the rising edge. Each accepted request is handed to the scoreboard, which
// keeps its own copy of the walk and queues the result it expects; each
// result taken from the unit is checked against the oldest expectation.
// A short directed part covers the idle walk, the grid edges, the clamping
// of the size and start registers and the single-cell grid. After that come
// random phases: new settings, a restart, and a walk that is mostly steered
// towards unvisited cells so that walks really finish, with rejected moves,
// abandoned walks and steps past the end mixed in.

module random_walk_spanning_tree_maze_unit_tb;
  import rwst_pkg::*;
  import maze_walk_sb_pkg::*;

  localparam int unsigned ITEM_TARGET    = 1150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  op_i;
  logic [1:0]            direction_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  accepted_o;
  logic                  carved_o;
  logic [POS_OUT_W-1:0]  wall_col_o;
  logic [POS_OUT_W-1:0]  wall_row_o;
  logic                  wall_side_o;
  logic [POS_OUT_W-1:0]  walker_col_o;
  logic [POS_OUT_W-1:0]  walker_row_o;
  logic [CNT_OUT_W-1:0]  cells_left_o;
  logic                  done_res_o;

  maze_walk_scoreboard sb;
  int unsigned         requests_sent = 0;
  int unsigned         send_run      = 0;
  int unsigned         take_run      = 0;
  int unsigned         idle_cycles   = 0;

  random_walk_spanning_tree_maze_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Draws the wait ahead of the next request. Now and then a stretch of
  // back-to-back requests starts, so that full rate is exercised too.
  function automatic int unsigned draw_gap(inout int unsigned run_left);
    if (run_left == 0 && $urandom_range(0, 15) == 0) run_left = $urandom_range(10, 40);
    if (run_left != 0) begin
      run_left--;
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Valid stays high from one request to the next when no gap is drawn, so
  // it is never lowered and raised within the same time step.
  task automatic send_request(input logic op, input logic [1:0] dir);
    int unsigned gap;
    gap = draw_gap(send_run);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    op_i        = op;
    direction_i = dir;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(op, dir);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic step(input logic [1:0] dir);
    send_request(OP_STEP, dir);
  endtask

  task automatic restart();
    send_request(OP_RESTART, DIR_LEFT);
  endtask

  // The sender holds back until every outstanding request has its result.
  task automatic wait_all_results();
    in_valid_i = 1'b0;
    while (sb.walk_results_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Mostly small grids so that walks finish; zero and oversized values
  // check the clamping, and full capacity turns up now and then.
  function automatic logic [CFG_DATA_W-1:0] pick_grid_size();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(33, 63));
      2: return CFG_DATA_W'(MAX_COLS_DEF);
      3, 4: return CFG_DATA_W'($urandom_range(9, 31));
      default: return CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  // The top data bit lies beyond the start registers and must be dropped.
  function automatic logic [CFG_DATA_W-1:0] pick_start();
    if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(0, 63));
    return CFG_DATA_W'($urandom_range(0, 7));
  endfunction

  // Steers towards an unvisited neighbour more often than not; otherwise
  // any direction, off-grid moves included.
  function automatic logic [1:0] pick_direction();
    logic [1:0] open_dirs[$];
    if ($urandom_range(0, 9) < 4) return 2'($urandom_range(0, 3));
    if (sb.walker_col > 0 && !sb.visited[sb.walker_row][sb.walker_col - 1])
      open_dirs.push_back(DIR_LEFT);
    if (sb.walker_col + 1 < sb.grid_cols && !sb.visited[sb.walker_row][sb.walker_col + 1])
      open_dirs.push_back(DIR_RIGHT);
    if (sb.walker_row > 0 && !sb.visited[sb.walker_row - 1][sb.walker_col])
      open_dirs.push_back(DIR_UP);
    if (sb.walker_row + 1 < sb.grid_rows && !sb.visited[sb.walker_row + 1][sb.walker_col])
      open_dirs.push_back(DIR_DOWN);
    if (open_dirs.size() == 0) return 2'($urandom_range(0, 3));
    return open_dirs[$urandom_range(0, open_dirs.size() - 1)];
  endfunction

  task automatic directed_walks();
    // Before the first restart the walk is idle: every step is refused and
    // reports done.
    step(DIR_LEFT);
    step(DIR_RIGHT);
    step(DIR_UP);
    step(DIR_DOWN);
    // The reset grid of 20 by 24 from the corner: both edges refuse, then
    // three carves (left wall, top wall, left wall of the cell being left),
    // then two moves into cells already visited.
    restart();
    step(DIR_LEFT);
    step(DIR_UP);
    step(DIR_RIGHT);
    step(DIR_DOWN);
    step(DIR_LEFT);
    step(DIR_UP);
    step(DIR_RIGHT);
    // Zero columns become one, and a start far outside lands on the single
    // cell, so the walk is done at once.
    wait_all_results();
    write_reg(CFG_GRID_COLS, '0);
    write_reg(CFG_GRID_ROWS, 6'd1);
    write_reg(CFG_START_COL, '1);
    write_reg(CFG_START_ROW, '1);
    restart();
    step(DIR_RIGHT);
    // Oversized values clamp to the full grid; start in the last cell.
    wait_all_results();
    write_reg(CFG_GRID_COLS, '1);
    write_reg(CFG_GRID_ROWS, '1);
    write_reg(CFG_START_COL, 6'd31);
    write_reg(CFG_START_ROW, 6'd31);
    restart();
    step(DIR_RIGHT);
    step(DIR_DOWN);
    step(DIR_LEFT);
    step(DIR_UP);
    // A single full-width row, with the start row clamped to it. The write
    // to the first index past the register file must change nothing.
    wait_all_results();
    write_reg(CFG_GRID_COLS, 6'd32);
    write_reg(CFG_GRID_ROWS, 6'd1);
    write_reg(CFG_START_COL, 6'd5);
    write_reg(CFG_START_ROW + 3'd1, '1);
    restart();
    step(DIR_UP);
    step(DIR_DOWN);
  endtask

  task automatic random_walk_phase();
    int unsigned budget;
    wait_all_results();
    write_reg(CFG_GRID_COLS, pick_grid_size());
    write_reg(CFG_GRID_ROWS, pick_grid_size());
    write_reg(CFG_START_COL, pick_start());
    write_reg(CFG_START_ROW, pick_start());
    // Sometimes the previous walk carries on first: new settings must wait
    // for the restart before they apply.
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) step(pick_direction());
    end
    restart();
    budget = (sb.cells_left > 60) ? 150 : 400;
    while (sb.cells_left != 0 && budget != 0 && requests_sent < ITEM_TARGET) begin
      budget--;
      case ($urandom_range(0, 49))
        0: restart();
        1: wait_all_results();
        default: step(pick_direction());
      endcase
    end
    // A few more steps, which must all be refused if the walk has reached its end.
    repeat ($urandom_range(0, 4)) step(2'($urandom_range(0, 3)));
  endtask

  // Result side: a random stall ahead of each result, then ready is held
  // until one is taken.
  initial begin : result_sink
    int unsigned  stall;
    walk_result_t got;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = draw_gap(take_run);
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = {accepted_o, carved_o, wall_col_o, wall_row_o, wall_side_o,
             walker_col_o, walker_row_o, cells_left_o, done_res_o};
      sb.check_result(got);
      @(negedge clk_i);
    end
  end

  // Any accepted request, result or register write restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (((in_valid_i && in_ready_o) === 1'b1) || ((out_valid_o && out_ready_i) === 1'b1) ||
          ((cfg_valid_i && cfg_ready_o) === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    op_i        = OP_STEP;
    direction_i = DIR_LEFT;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GRID_COLS;
    cfg_data_i  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    directed_walks();
    while (requests_sent < ITEM_TARGET) random_walk_phase();
    wait_all_results();
    // Let any stray result show itself before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rwst_pkg.sv
rtl/rwst_map.sv
rtl/rwst_move.sv
rtl/random_walk_spanning_tree_maze_unit.sv
verif/maze_walk_sb_pkg.sv
verif/random_walk_spanning_tree_maze_unit_tb.sv
